>>> src/two_level_fifo_cache_lookup_macros.svh
// ----------------------------------------------------------------------------
// two_level_fifo_cache_lookup_macros
// Assertion macros shared by the cache lookup modules.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_FIFO_CACHE_LOOKUP_MACROS_SVH
`define TWO_LEVEL_FIFO_CACHE_LOOKUP_MACROS_SVH

// clocked check, off while reset is asserted
`define TFLC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tflc check failed");

// same, with a caller message
`define TFLC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> src/tflc_pkg.sv
// ----------------------------------------------------------------------------
// tflc_pkg
// Shared types and constants of the two-level FIFO cache lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tflc_pkg;

    localparam int L1_MAX_SETS_DEF = 64;
    localparam int L1_MAX_WAYS_DEF = 8;
    localparam int L2_MAX_SETS_DEF = 512;
    localparam int L2_MAX_WAYS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int ADDR_W     = 32;
    localparam int FRAME_W    = 20;
    localparam int PSHIFT_W   = 5;
    localparam int PAGE_W     = 52;   // (frame + 1) << 31 fits
    localparam int BA_W       = 54;   // tag, set and block offset rebuilt
    localparam int TAG_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int LAT_W      = 7;
    localparam int SERVED_W   = 2;
    localparam int BSHIFT_W   = 4;
    localparam int L1_SS_W    = 3;
    localparam int L1_WAYS_W  = 4;
    localparam int L2_SS_W    = 4;
    localparam int L2_WAYS_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 144;
    localparam int QDEPTH     = 2;

    localparam int LAT_L1  = 1;
    localparam int LAT_L2  = 10;
    localparam int LAT_MEM = 100;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L1_BLOCK_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L1_SET_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_L1_WAYS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_L2_BLOCK_SHIFT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_L2_SET_SHIFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_L2_WAYS        = 3'd6;

    typedef enum logic [SERVED_W-1:0] {
        SRV_L1  = 2'd0,
        SRV_L2  = 2'd1,
        SRV_MEM = 2'd2,
        SRV_INV = 2'd3
    } served_t;

    typedef enum logic {
        OP_ACCESS = 1'b0,
        OP_INVAL  = 1'b1
    } lvl_op_t;

    typedef struct packed {
        logic    start;
        lvl_op_t op;
    } lvl_cmd_t;

    typedef struct packed {
        logic idle;
        logic hit;
    } lvl_stat_t;

    typedef struct packed {
        logic              inval;
        logic [ADDR_W-1:0] addr;
        logic [PAGE_W-1:0] lo;
        logic [PAGE_W-1:0] hi;
    } qent_t;

    typedef struct packed {
        logic [1:0]           level_enable;
        logic [BSHIFT_W-1:0]  l1_bshift;
        logic [L1_SS_W-1:0]   l1_sshift;
        logic [L1_WAYS_W-1:0] l1_ways;
        logic [BSHIFT_W-1:0]  l2_bshift;
        logic [L2_SS_W-1:0]   l2_sshift;
        logic [L2_WAYS_W-1:0] l2_ways;
    } cfg_t;

endpackage

>>> src/tflc_front.sv
// ----------------------------------------------------------------------------
// tflc_front
// Accepts items, decodes access address or page bounds, queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tflc_front #(
    parameter int ADDR_BITS = tflc_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tflc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output tflc_pkg::qent_t                q_ent
);
    import tflc_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
        : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    qent_t             ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;
    qent_t             dec;
    logic              push, pop;
    logic [PAGE_W-1:0] frame_x;
    logic [PSHIFT_W-1:0] ps;

    always_comb
    begin
        frame_x   = PAGE_W'(s_axis_tdata[ADDR_W +: FRAME_W]);
        ps        = s_axis_tdata[ADDR_W + FRAME_W +: PSHIFT_W];
        dec.inval = s_axis_tuser[0];
        dec.addr  = s_axis_tdata[ADDR_W-1:0] & ADDR_MASK;
        dec.lo    = frame_x << ps;
        dec.hi    = (frame_x + PAGE_W'(1)) << ps;
    end

    assign s_axis_tready = (cnt_reg < (QPTR_W+1)'(QDEPTH));
    assign q_valid       = (cnt_reg != '0);
    assign q_ent         = ent_reg[rp_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == QPTR_W'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == QPTR_W'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= dec;
    end

endmodule

>>> src/tflc_level.sv
// ----------------------------------------------------------------------------
// tflc_level
// One set-associative tag level: lookup with FIFO fill, page invalidate,
// clearing pass, and its hit and miss counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_fifo_cache_lookup_macros.svh"

module tflc_level #(
    parameter int MAX_SETS   = tflc_pkg::L1_MAX_SETS_DEF,
    parameter int MAX_WAYS   = tflc_pkg::L1_MAX_WAYS_DEF,
    parameter int SS_CFG_W   = tflc_pkg::L1_SS_W,
    parameter int WAYS_CFG_W = tflc_pkg::L1_WAYS_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr,
    input  tflc_pkg::lvl_cmd_t            cmd,
    input  logic [tflc_pkg::ADDR_W-1:0]   addr,
    input  logic [tflc_pkg::PAGE_W-1:0]   lo,
    input  logic [tflc_pkg::PAGE_W-1:0]   hi,
    input  logic [tflc_pkg::BSHIFT_W-1:0] bshift,
    input  logic [SS_CFG_W-1:0]           sshift,
    input  logic [WAYS_CFG_W-1:0]         ways,
    output tflc_pkg::lvl_stat_t           stat,
    output logic [tflc_pkg::CNT_W-1:0]    hit_count,
    output logic [tflc_pkg::CNT_W-1:0]    miss_count
);
    import tflc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SS_LIM = $clog2(MAX_SETS + 1) - 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_ARD   = 8'b0000_0100,
        ST_CMP   = 8'b0000_1000,
        ST_SCAN  = 8'b0001_0000,
        ST_FILL  = 8'b0010_0000,
        ST_IRD   = 8'b0100_0000,
        ST_IWR   = 8'b1000_0000
    } lvl_state_t;

    logic [MAX_WAYS-1:0]              vmem [MAX_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tmem [MAX_SETS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0] smem [MAX_SETS];

    lvl_state_t        state_reg, state_next;
    logic [SET_W-1:0]  cnt_reg, cnt_next;
    logic [WAY_W-1:0]  w_reg, w_next, vic_reg, vic_next;
    logic              hit_reg, hit_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next, miss_cnt_reg, miss_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PAGE_W-1:0] lo_reg, lo_next, hi_reg, hi_next;

    logic [MAX_WAYS-1:0]              rv_reg;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   rt_reg;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] rs_reg;

    logic                             re, we_v, we_ts;
    logic [SET_W-1:0]                 ra, wa;
    logic [MAX_WAYS-1:0]              wv;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   wt;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] ws;

    logic [4:0]          ss_eff;
    logic [WAY_W:0]      n_eff;
    logic [ADDR_W-1:0]   blk, set_mask, tag_v;
    logic [SET_W-1:0]    set_idx;
    logic [MAX_WAYS-1:0] match, kill;
    logic [BA_W-1:0]     ba;

    always_comb
    begin
        ss_eff = (sshift > SS_LIM) ? 5'(SS_LIM) : 5'(sshift);
        if (ways == '0)
            n_eff = (WAY_W+1)'(1);
        else if (ways > MAX_WAYS)
            n_eff = (WAY_W+1)'(MAX_WAYS);
        else
            n_eff = (WAY_W+1)'(ways);
        blk      = addr_reg >> bshift;
        set_mask = (ADDR_W'(1) << ss_eff) - ADDR_W'(1);
        set_idx  = SET_W'(blk & set_mask);
        tag_v    = blk >> ss_eff;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match[w] = rv_reg[w] && (rt_reg[w] == tag_v) && ((WAY_W+1)'(w) < n_eff);
            // block address of the line: tag, set, then block offset
            ba = ((BA_W'(rt_reg[w]) << ss_eff) | BA_W'(cnt_reg)) << bshift;
            kill[w] = rv_reg[w] && ((WAY_W+1)'(w) < n_eff)
                && (ba >= BA_W'(lo_reg)) && (ba < BA_W'(hi_reg));
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        w_next        = w_reg;
        vic_next      = vic_reg;
        hit_next      = hit_reg;
        clock_next    = clock_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        addr_next     = addr_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        re    = 1'b0;
        ra    = set_idx;
        we_v  = 1'b0;
        we_ts = 1'b0;
        wa    = set_idx;
        wv    = rv_reg;
        wt    = rt_reg;
        ws    = rs_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we_v = 1'b1;
                wa   = cnt_reg;
                wv   = '0;
                if (cnt_reg == SET_W'(MAX_SETS - 1))
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    addr_next = addr;
                    lo_next   = lo;
                    hi_next   = hi;
                    cnt_next  = '0;
                    state_next = (cmd.op == OP_INVAL) ? ST_IRD : ST_ARD;
                end
            end
            ST_ARD:
            begin
                re = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (match != '0)
                begin
                    hit_next = 1'b1;
                    if (hit_cnt_reg != '1)
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    hit_next = 1'b0;
                    if (miss_cnt_reg != '1)
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    w_next     = '0;
                    vic_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // first empty way wins, else oldest stamp, lowest way on ties
                if (!rv_reg[w_reg])
                begin
                    vic_next   = w_reg;
                    state_next = ST_FILL;
                end
                else
                begin
                    if (rs_reg[w_reg] < rs_reg[vic_reg])
                        vic_next = w_reg;
                    if ({1'b0, w_reg} == n_eff - 1'b1)
                        state_next = ST_FILL;
                    else
                        w_next = w_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                we_v  = 1'b1;
                we_ts = 1'b1;
                wv[vic_reg] = 1'b1;
                wt[vic_reg] = tag_v;
                ws[vic_reg] = clock_reg;
                clock_next  = clock_reg + 1'b1;
                state_next  = ST_IDLE;
            end
            ST_IRD:
            begin
                re = 1'b1;
                ra = cnt_reg;
                state_next = ST_IWR;
            end
            ST_IWR:
            begin
                we_v = 1'b1;
                wa   = cnt_reg;
                wv   = rv_reg & ~kill;
                if (ADDR_W'(cnt_reg) == set_mask)
                    state_next = ST_IDLE;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_IRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clr)
        begin
            state_next    = ST_CLEAR;
            cnt_next      = '0;
            clock_next    = '0;
            hit_cnt_next  = '0;
            miss_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            w_reg        <= '0;
            vic_reg      <= '0;
            hit_reg      <= 1'b0;
            clock_reg    <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            w_reg        <= w_next;
            vic_reg      <= vic_next;
            hit_reg      <= hit_next;
            clock_reg    <= clock_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (we_v)
            vmem[wa] <= wv;
        if (we_ts)
        begin
            tmem[wa] <= wt;
            smem[wa] <= ws;
        end
        if (re)
        begin
            rv_reg <= vmem[ra];
            rt_reg <= tmem[ra];
            rs_reg <= smem[ra];
        end
    end

    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.hit   = hit_reg;
    assign hit_count  = hit_cnt_reg;
    assign miss_count = miss_cnt_reg;

    `TFLC_ASSERT(a_start_when_idle, cmd.start |-> (state_reg == ST_IDLE))
    `TFLC_ASSERT(a_hits_no_drop, !clr |=> (hit_cnt_reg >= $past(hit_cnt_reg)))
    `TFLC_ASSERT_MSG(a_inval_keeps_counts, (state_reg == ST_IWR && !clr) |=> $stable(miss_cnt_reg), "invalidate touched miss count")

endmodule

>>> src/tflc_back.sv
// ----------------------------------------------------------------------------
// tflc_back
// Carries out queued items over both levels and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_fifo_cache_lookup_macros.svh"

module tflc_back #(
    parameter int L1_MAX_SETS = tflc_pkg::L1_MAX_SETS_DEF,
    parameter int L1_MAX_WAYS = tflc_pkg::L1_MAX_WAYS_DEF,
    parameter int L2_MAX_SETS = tflc_pkg::L2_MAX_SETS_DEF,
    parameter int L2_MAX_WAYS = tflc_pkg::L2_MAX_WAYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tflc_pkg::cfg_t                  cfg,
    input  logic                            clr1,
    input  logic                            clr2,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  tflc_pkg::qent_t                 q_ent,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tflc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tflc_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_L1   = 4'b0010,
        B_L2   = 4'b0100,
        B_INV  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    lvl_cmd_t    l1_cmd, l2_cmd;
    lvl_stat_t   l1_stat, l2_stat;
    logic [CNT_W-1:0] l1_hits, l1_miss, l2_hits, l2_miss;
    logic        en1, en2, lvl_idle, res_load;
    served_t     res_served;
    logic [LAT_W-1:0] res_lat;
    logic        out_valid_reg;
    served_t     out_served_reg;
    logic [LAT_W-1:0] out_lat_reg;
    logic [CNT_W-1:0] out_c0_reg, out_c1_reg, out_c2_reg, out_c3_reg;

    assign en1      = cfg.level_enable[0];
    assign en2      = cfg.level_enable[1];
    assign lvl_idle = l1_stat.idle && l2_stat.idle;

    tflc_level #(
        .MAX_SETS   (L1_MAX_SETS),
        .MAX_WAYS   (L1_MAX_WAYS),
        .SS_CFG_W   (L1_SS_W),
        .WAYS_CFG_W (L1_WAYS_W)
    ) u_l1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (clr1),
        .cmd        (l1_cmd),
        .addr       (q_ent.addr),
        .lo         (q_ent.lo),
        .hi         (q_ent.hi),
        .bshift     (cfg.l1_bshift),
        .sshift     (cfg.l1_sshift),
        .ways       (cfg.l1_ways),
        .stat       (l1_stat),
        .hit_count  (l1_hits),
        .miss_count (l1_miss)
    );

    tflc_level #(
        .MAX_SETS   (L2_MAX_SETS),
        .MAX_WAYS   (L2_MAX_WAYS),
        .SS_CFG_W   (L2_SS_W),
        .WAYS_CFG_W (L2_WAYS_W)
    ) u_l2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (clr2),
        .cmd        (l2_cmd),
        .addr       (q_ent.addr),
        .lo         (q_ent.lo),
        .hi         (q_ent.hi),
        .bshift     (cfg.l2_bshift),
        .sshift     (cfg.l2_sshift),
        .ways       (cfg.l2_ways),
        .stat       (l2_stat),
        .hit_count  (l2_hits),
        .miss_count (l2_miss)
    );

    always_comb
    begin
        state_next = state_reg;
        l1_cmd     = '{start: 1'b0, op: OP_ACCESS};
        l2_cmd     = '{start: 1'b0, op: OP_ACCESS};
        res_load   = 1'b0;
        res_served = SRV_MEM;
        res_lat    = LAT_W'(LAT_L1 + LAT_L2 + LAT_MEM);

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg && lvl_idle)
                begin
                    if (q_ent.inval)
                    begin
                        l1_cmd     = '{start: en1, op: OP_INVAL};
                        l2_cmd     = '{start: en2, op: OP_INVAL};
                        state_next = B_INV;
                    end
                    else if (en1)
                    begin
                        l1_cmd.start = 1'b1;
                        state_next   = B_L1;
                    end
                    else if (en2)
                    begin
                        l2_cmd.start = 1'b1;
                        state_next   = B_L2;
                    end
                    else
                        res_load = 1'b1;
                end
            end
            B_L1:
            begin
                if (lvl_idle)
                begin
                    if (l1_stat.hit)
                    begin
                        res_load   = 1'b1;
                        res_served = SRV_L1;
                        res_lat    = LAT_W'(LAT_L1);
                        state_next = B_IDLE;
                    end
                    else if (en2)
                    begin
                        l2_cmd.start = 1'b1;
                        state_next   = B_L2;
                    end
                    else
                    begin
                        res_load   = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
            B_L2:
            begin
                if (lvl_idle)
                begin
                    res_load = 1'b1;
                    if (l2_stat.hit)
                    begin
                        res_served = SRV_L2;
                        res_lat    = LAT_W'(LAT_L1 + LAT_L2);
                    end
                    state_next = B_IDLE;
                end
            end
            B_INV:
            begin
                if (lvl_idle)
                begin
                    res_load   = 1'b1;
                    res_served = SRV_INV;
                    res_lat    = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // queue head stays in place until its result is loaded into the output register
        q_ready = res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_served_reg <= res_served;
            out_lat_reg    <= res_lat;
            out_c0_reg     <= l1_hits;
            out_c1_reg     <= l1_miss;
            out_c2_reg     <= l2_hits;
            out_c3_reg     <= l2_miss;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_c3_reg, out_c2_reg, out_c1_reg, out_c0_reg,
                            out_lat_reg, out_served_reg};

    `TFLC_ASSERT(a_no_start_when_full, (l1_cmd.start || l2_cmd.start) |-> !out_valid_reg)
    `TFLC_ASSERT(a_pop_only_valid, q_ready |-> q_valid)
    `TFLC_ASSERT(a_l1_latency, (out_valid_reg && out_served_reg == SRV_L1) |-> (out_lat_reg == LAT_W'(LAT_L1)))

endmodule

>>> src/two_level_fifo_cache_lookup.sv
// ----------------------------------------------------------------------------
// two_level_fifo_cache_lookup
// Two-level set-associative tag store with FIFO replacement.
// ----------------------------------------------------------------------------
// An item is either an access (tuser 0) or a page invalidate (tuser 1) and
// gives one result item. A two-entry queue takes items while the back end
// works; its head entry stays queued until the back end loads its result.
// Each level reads one whole set per cycle from its tag memory; on a
// miss the victim scan checks one way per cycle, and a miss in L1 goes
// on to L2 when it is enabled. An invalidate walks the configured sets
// one after another, both levels at once. After reset, and after a
// write to any configuration register, the affected level runs a
// clearing pass over all L1_MAX_SETS or L2_MAX_SETS sets during which
// no item starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_fifo_cache_lookup #(
    parameter int L1_MAX_SETS = tflc_pkg::L1_MAX_SETS_DEF,
    parameter int L1_MAX_WAYS = tflc_pkg::L1_MAX_WAYS_DEF,
    parameter int L2_MAX_SETS = tflc_pkg::L2_MAX_SETS_DEF,
    parameter int L2_MAX_WAYS = tflc_pkg::L2_MAX_WAYS_DEF,
    parameter int ADDR_BITS   = tflc_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[31:0], frame[51:32], page_shift[56:52], zero fill
    input  logic [tflc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // served_by[1:0], latency_cycles[8:2], l1_hit_count[40:9],
    // l1_miss_count[72:41], l2_hit_count[104:73], l2_miss_count[136:105]
    output logic [tflc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [tflc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tflc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tflc_pkg::*;

    cfg_t  cfg_reg;
    logic  clr1, clr2, q_valid, q_ready;
    qent_t q_ent;

    // writing the enables resets both levels; a geometry write resets its own
    always_comb
    begin
        clr1 = 1'b0;
        clr2 = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_ENABLE:
                begin
                    clr1 = 1'b1;
                    clr2 = 1'b1;
                end
                REG_L1_BLOCK_SHIFT, REG_L1_SET_SHIFT, REG_L1_WAYS: clr1 = 1'b1;
                REG_L2_BLOCK_SHIFT, REG_L2_SET_SHIFT, REG_L2_WAYS: clr2 = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_enable <= 2'd0;
            cfg_reg.l1_bshift    <= 4'd6;
            cfg_reg.l1_sshift    <= 3'd0;
            cfg_reg.l1_ways      <= 4'd1;
            cfg_reg.l2_bshift    <= 4'd6;
            cfg_reg.l2_sshift    <= 4'd0;
            cfg_reg.l2_ways      <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_ENABLE:   cfg_reg.level_enable <= cfg_wdata[1:0];
                REG_L1_BLOCK_SHIFT: cfg_reg.l1_bshift    <= cfg_wdata[BSHIFT_W-1:0];
                REG_L1_SET_SHIFT:   cfg_reg.l1_sshift    <= cfg_wdata[L1_SS_W-1:0];
                REG_L1_WAYS:        cfg_reg.l1_ways      <= cfg_wdata[L1_WAYS_W-1:0];
                REG_L2_BLOCK_SHIFT: cfg_reg.l2_bshift    <= cfg_wdata[BSHIFT_W-1:0];
                REG_L2_SET_SHIFT:   cfg_reg.l2_sshift    <= cfg_wdata[L2_SS_W-1:0];
                REG_L2_WAYS:        cfg_reg.l2_ways      <= cfg_wdata[L2_WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    tflc_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_ent         (q_ent)
    );

    tflc_back #(
        .L1_MAX_SETS (L1_MAX_SETS),
        .L1_MAX_WAYS (L1_MAX_WAYS),
        .L2_MAX_SETS (L2_MAX_SETS),
        .L2_MAX_WAYS (L2_MAX_WAYS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clr1          (clr1),
        .clr2          (clr2),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_ent         (q_ent),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
